>>> hw/rtl/vdi_pkg.sv
// Shared types and constants for the vertex dedup indexer.
`default_nettype none

package vdi_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned GRP_SIZE = 16;
  localparam int unsigned GRP_W    = 4;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned UCNT_W   = 9;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_ADD   = 1'b1;

  localparam logic [1:0] VTX_A = 2'd0;
  localparam logic [1:0] VTX_B = 2'd1;
  localparam logic [1:0] VTX_C = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic             any;
    logic [GRP_W-1:0] loc;
  } grp_res_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_GRP  = 5'b00100,
    S_DEC  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

>>> hw/rtl/vdi_cell.sv
// One storage cell of the vertex chain: holds an entry, shifts, compares.
`default_nettype none

module vdi_cell (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              shift_i,
  input  wire              occ_i,
  input  wire vdi_pkg::vertex_t prev_i,
  input  wire vdi_pkg::vertex_t query_i,
  output vdi_pkg::vertex_t entry_o,
  output logic             hit_o
);
  import vdi_pkg::*;

  vertex_t entry_q;
  logic    hit_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= occ_i && (entry_q == query_i);
    end
  end

  assign entry_o = entry_q;
  assign hit_o   = hit_q;

endmodule

`default_nettype wire

>>> hw/rtl/vdi_grp_enc.sv
// Registered hit encoder for one group of cells.
`default_nettype none

module vdi_grp_enc (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire  [vdi_pkg::GRP_SIZE-1:0]       hit_i,
  output vdi_pkg::grp_res_t                  res_o
);
  import vdi_pkg::*;

  grp_res_t res_d;
  grp_res_t res_q;

  always_comb begin
    res_d = '0;
    for (int j = 0; j < GRP_SIZE; j++) begin
      if (hit_i[j]) begin
        res_d.any = 1'b1;
        res_d.loc = res_d.loc | GRP_W'(j);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

>>> hw/rtl/vertex_dedup_indexer.sv
// Top level of the vertex dedup indexer: cell chain, encoders and sequencer.
//
// Welds a triangle soup into an indexed face set. Each add request carries
// three vertices, matched in order A, B, C against a chain of MAX_VERTICES
// cells that all compare in parallel; a vertex with no match is shifted in
// at the head of the chain and gets the next index. Each vertex goes in turn
// through a cell compare, a group encode, and a decide and append step.
// One request is in flight at a time; a new one is accepted while the last
// result still waits in the output register. On overflow a vertex is not
// stored, its index reads 0 and full_res is set for that request.
`default_nettype none

module vertex_dedup_indexer #(
  parameter int unsigned MAX_VERTICES = 256
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire                              command_i,
  input  wire  [vdi_pkg::COORD_W-1:0]      ax_i,
  input  wire  [vdi_pkg::COORD_W-1:0]      ay_i,
  input  wire  [vdi_pkg::COORD_W-1:0]      az_i,
  input  wire  [vdi_pkg::COORD_W-1:0]      bx_i,
  input  wire  [vdi_pkg::COORD_W-1:0]      by_coord_i,
  input  wire  [vdi_pkg::COORD_W-1:0]      bz_i,
  input  wire  [vdi_pkg::COORD_W-1:0]      cx_i,
  input  wire  [vdi_pkg::COORD_W-1:0]      cy_i,
  input  wire  [vdi_pkg::COORD_W-1:0]      cz_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [vdi_pkg::IDX_W-1:0]        index_a_o,
  output logic [vdi_pkg::IDX_W-1:0]        index_b_o,
  output logic [vdi_pkg::IDX_W-1:0]        index_c_o,
  output logic                             new_a_o,
  output logic                             new_b_o,
  output logic                             new_c_o,
  output logic [vdi_pkg::UCNT_W-1:0]       unique_count_o,
  output logic                             full_res_o
);
  import vdi_pkg::*;

  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned NG = (MAX_VERTICES + GRP_SIZE - 1) / GRP_SIZE;

  state_e  state_q, state_d;
  logic [1:0]    vsel_q;
  logic [CW-1:0] count_q;
  vertex_t va_q, vb_q, vc_q;
  vertex_t query;

  logic [IDX_W-1:0] idx_q [3];
  logic [2:0]       new_q;
  logic             full_q;

  logic                 out_valid_q;
  logic [IDX_W-1:0]     out_idx_a_q, out_idx_b_q, out_idx_c_q;
  logic [2:0]           out_new_q;
  logic [UCNT_W-1:0]    out_ucnt_q;
  logic                 out_full_q;

  vertex_t entry [MAX_VERTICES];
  vertex_t prev  [MAX_VERTICES];
  logic [NG*GRP_SIZE-1:0] hit;
  grp_res_t grp [NG];
  logic [NG-1:0] grp_any;

  logic          shift_en;
  logic          any_hit;
  logic [CW-1:0] hit_pos;
  logic          room;
  logic          in_acc;
  logic          out_free;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    case (vsel_q)
      VTX_A:   query = va_q;
      VTX_B:   query = vb_q;
      VTX_C:   query = vc_q;
      default: query = va_q;
    endcase
  end

  // cell chain; a new entry enters at cell 0 and older ones move down
  for (genvar p = 0; p < NG * GRP_SIZE; p++) begin : g_lane
    if (p < MAX_VERTICES) begin : g_cell
      if (p == 0) begin : g_head
        assign prev[p] = query;
      end else begin : g_link
        assign prev[p] = entry[p-1];
      end
      vdi_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift_en),
        .occ_i   (count_q > CW'(p)),
        .prev_i  (prev[p]),
        .query_i (query),
        .entry_o (entry[p]),
        .hit_o   (hit[p])
      );
    end else begin : g_pad
      assign hit[p] = 1'b0;
    end
  end

  for (genvar g = 0; g < NG; g++) begin : g_grp
    vdi_grp_enc u_enc (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .hit_i  (hit[g*GRP_SIZE +: GRP_SIZE]),
      .res_o  (grp[g])
    );
    assign grp_any[g] = grp[g].any;
  end

  // entries are unique, so at most one group reports a hit
  always_comb begin
    any_hit = 1'b0;
    hit_pos = '0;
    for (int g = 0; g < NG; g++) begin
      if (grp[g].any) begin
        any_hit = 1'b1;
        hit_pos = hit_pos | CW'(g * GRP_SIZE) | CW'(grp[g].loc);
      end
    end
  end

  assign room     = count_q < CW'(MAX_VERTICES);
  assign shift_en = (state_q == S_DEC) && !any_hit && room;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (command_i == CMD_CLEAR) ? S_OUT : S_CMP;
        end
      end
      S_CMP: state_d = S_GRP;
      S_GRP: state_d = S_DEC;
      S_DEC: state_d = (vsel_q == VTX_C) ? S_OUT : S_CMP;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vsel_q  <= VTX_A;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        vsel_q <= VTX_A;
        if (command_i == CMD_CLEAR) begin
          count_q <= '0;
        end
      end else if (state_q == S_DEC) begin
        vsel_q <= vsel_q + 2'd1;
        if (shift_en) begin
          count_q <= count_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      va_q   <= '{x: ax_i, y: ay_i,       z: az_i};
      vb_q   <= '{x: bx_i, y: by_coord_i, z: bz_i};
      vc_q   <= '{x: cx_i, y: cy_i,       z: cz_i};
      idx_q  <= '{default: '0};
      new_q  <= '0;
      full_q <= 1'b0;
    end else if (state_q == S_DEC) begin
      if (any_hit) begin
        idx_q[vsel_q] <= IDX_W'(count_q - CW'(1) - hit_pos);
      end else if (room) begin
        idx_q[vsel_q] <= IDX_W'(count_q);
        new_q[vsel_q] <= 1'b1;
      end else begin
        full_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_idx_a_q <= idx_q[0];
      out_idx_b_q <= idx_q[1];
      out_idx_c_q <= idx_q[2];
      out_new_q   <= new_q;
      out_ucnt_q  <= UCNT_W'(count_q);
      out_full_q  <= full_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign index_a_o      = out_idx_a_q;
  assign index_b_o      = out_idx_b_q;
  assign index_c_o      = out_idx_c_q;
  assign new_a_o        = out_new_q[0];
  assign new_b_o        = out_new_q[1];
  assign new_c_o        = out_new_q[2];
  assign unique_count_o = out_ucnt_q;
  assign full_res_o     = out_full_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_VERTICES))
    else $error("vertex count above table size");

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DEC |-> $onehot0(grp_any))
    else $error("more than one group matched");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_en |=> count_q == $past(count_q) + CW'(1))
    else $error("append did not advance count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_full_q |-> out_ucnt_q == UCNT_W'(MAX_VERTICES))
    else $error("full reported below table size");
`endif

endmodule

`default_nettype wire
